/* sv/cpu_6502_subset_core_macros.svh */
// Assertion macros used by the 6502 subset core top level.
`ifndef CPU_6502_SUBSET_CORE_MACROS_SVH
`define CPU_6502_SUBSET_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("core assertion failed");

// Next-cycle implication, checked outside reset.
`define CPU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("core assertion failed");

`endif

/* sv/cpu6502_pkg.sv */
// Shared types, opcodes and register indexes for the 6502 subset core.
`timescale 1ns / 1ps
package cpu6502_pkg;

   localparam int CsrAddrWidth = 4;

   localparam logic [1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_STACK_START   = 2'd1;
   localparam logic [1:0] CSR_STATUS_START  = 2'd2;

   localparam logic CMD_START = 1'b0;

   localparam logic [7:0] OP_CLC      = 8'h18;
   localparam logic [7:0] OP_SEC      = 8'h38;
   localparam logic [7:0] OP_SEI      = 8'h78;
   localparam logic [7:0] OP_DEY      = 8'h88;
   localparam logic [7:0] OP_DEX      = 8'hCA;
   localparam logic [7:0] OP_INY      = 8'hC8;
   localparam logic [7:0] OP_INX      = 8'hE8;
   localparam logic [7:0] OP_TAX      = 8'hAA;
   localparam logic [7:0] OP_TAY      = 8'hA8;
   localparam logic [7:0] OP_TXA      = 8'h8A;
   localparam logic [7:0] OP_TYA      = 8'h98;
   localparam logic [7:0] OP_NOP      = 8'hEA;
   localparam logic [7:0] OP_PHA      = 8'h48;
   localparam logic [7:0] OP_PLA      = 8'h68;
   localparam logic [7:0] OP_RTS      = 8'h60;
   localparam logic [7:0] OP_RTI      = 8'h40;
   localparam logic [7:0] OP_ADC_IMM  = 8'h69;
   localparam logic [7:0] OP_AND_IMM  = 8'h29;
   localparam logic [7:0] OP_EOR_IMM  = 8'h49;
   localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
   localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
   localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
   localparam logic [7:0] OP_CMP_IMM  = 8'hC9;
   localparam logic [7:0] OP_BPL      = 8'h10;
   localparam logic [7:0] OP_BCC      = 8'h90;
   localparam logic [7:0] OP_BCS      = 8'hB0;
   localparam logic [7:0] OP_BNE      = 8'hD0;
   localparam logic [7:0] OP_BEQ      = 8'hF0;
   localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
   localparam logic [7:0] OP_CMP_ZP   = 8'hC5;
   localparam logic [7:0] OP_STA_ZP   = 8'h85;
   localparam logic [7:0] OP_STX_ZP   = 8'h86;
   localparam logic [7:0] OP_STY_ZP   = 8'h84;
   localparam logic [7:0] OP_DEC_ZP   = 8'hC6;
   localparam logic [7:0] OP_INC_ZP   = 8'hE6;
   localparam logic [7:0] OP_BIT_ABS  = 8'h2C;
   localparam logic [7:0] OP_CMP_ABS  = 8'hCD;
   localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
   localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
   localparam logic [7:0] OP_STA_ABS  = 8'h8D;
   localparam logic [7:0] OP_STX_ABS  = 8'h8E;
   localparam logic [7:0] OP_INC_ABS  = 8'hEE;
   localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
   localparam logic [7:0] OP_JSR      = 8'h20;
   localparam logic [7:0] OP_LDA_INDY = 8'hB1;

   localparam logic [2:0] STEP_IDLE  = 3'd0;
   localparam logic [2:0] STEP_FETCH = 3'd1;
   localparam logic [2:0] STEP_OPER  = 3'd2;
   localparam logic [2:0] STEP_3     = 3'd3;
   localparam logic [2:0] STEP_4     = 3'd4;
   localparam logic [2:0] STEP_5     = 3'd5;

   localparam logic [7:0] STACK_PAGE = 8'h01;

   typedef struct packed {
      logic [15:0] start_address;
      logic [7:0]  stack_start;
      logic [7:0]  status_start;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  p;
      logic [7:0]  sp;
      logic [15:0] pc;
      logic [7:0]  op;
      logic [2:0]  step;
      logic [15:0] oa;
      logic        halt;
      logic [7:0]  latch;
   } core_state_type;

   typedef struct packed {
      logic [15:0] bus_address;
      logic        bus_write;
      logic [7:0]  write_data;
      logic        instruction_done;
      logic [2:0]  instruction_cycles;
      logic        halted;
      logic [7:0]  flags_out;
   } result_type;

endpackage

/* sv/cpu6502_csr.sv */
// Start configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module cpu6502_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cpu6502_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   output cpu6502_pkg::cfg_type                 cfg
);
   cpu6502_pkg::cfg_type cfg_ff;
   logic                 wr_en;
   logic [1:0]           reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_address <= 16'h8000;
         cfg_ff.stack_start   <= 8'hFD;
         cfg_ff.status_start  <= 8'h24;
      end else if (wr_en) begin
         unique case (reg_sel)
            cpu6502_pkg::CSR_START_ADDRESS: cfg_ff.start_address <= csr_pwdata[15:0];
            cpu6502_pkg::CSR_STACK_START:   cfg_ff.stack_start   <= csr_pwdata[7:0];
            cpu6502_pkg::CSR_STATUS_START:  cfg_ff.status_start  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         cpu6502_pkg::CSR_START_ADDRESS: csr_prdata = {16'h0, cfg_ff.start_address};
         cpu6502_pkg::CSR_STACK_START:   csr_prdata = {24'h0, cfg_ff.stack_start};
         cpu6502_pkg::CSR_STATUS_START:  csr_prdata = {24'h0, cfg_ff.status_start};
         default:                        csr_prdata = 32'h0;
      endcase
   end
endmodule

/* sv/cpu6502_step.sv */
// Next-state and bus request logic for one bus cycle of the core.
`timescale 1ns / 1ps
module cpu6502_step (
   input  cpu6502_pkg::core_state_type cur,
   input  cpu6502_pkg::cfg_type        cfg,
   input  logic                        command,
   input  logic [7:0]                  read_data,
   output cpu6502_pkg::core_state_type nxt,
   output cpu6502_pkg::result_type     res
);
   function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] v);
      return {v[7], p[6:2], (v == 8'h00), p[0]};
   endfunction

   function automatic cpu6502_pkg::core_state_type apply_rd(
      cpu6502_pkg::core_state_type st, logic [7:0] m);
      logic [8:0] sum;
      logic [7:0] diff;
      cpu6502_pkg::core_state_type o;
      o    = st;
      sum  = {1'b0, st.a} + {1'b0, m} + {8'h00, st.p[0]};
      diff = st.a - m;
      unique case (st.op)
         cpu6502_pkg::OP_LDA_IMM, cpu6502_pkg::OP_LDA_ZP, cpu6502_pkg::OP_LDA_ABS,
         cpu6502_pkg::OP_LDA_ABSX, cpu6502_pkg::OP_LDA_INDY: begin
            o.a = m;
            o.p = set_nz(st.p, m);
         end
         cpu6502_pkg::OP_LDX_IMM: begin
            o.x = m;
            o.p = set_nz(st.p, m);
         end
         cpu6502_pkg::OP_LDY_IMM: begin
            o.y = m;
            o.p = set_nz(st.p, m);
         end
         cpu6502_pkg::OP_AND_IMM: begin
            o.a = st.a & m;
            o.p = set_nz(st.p, st.a & m);
         end
         cpu6502_pkg::OP_EOR_IMM: begin
            o.a = st.a ^ m;
            o.p = set_nz(st.p, st.a ^ m);
         end
         cpu6502_pkg::OP_CMP_IMM, cpu6502_pkg::OP_CMP_ZP, cpu6502_pkg::OP_CMP_ABS: begin
            o.p    = set_nz(st.p, diff);
            o.p[0] = (st.a >= m);
         end
         cpu6502_pkg::OP_BIT_ABS: begin
            o.p = {m[7:6], st.p[5:2], ((st.a & m) == 8'h00), st.p[0]};
         end
         cpu6502_pkg::OP_ADC_IMM: begin
            o.a    = sum[7:0];
            o.p    = set_nz(st.p, sum[7:0]);
            o.p[0] = sum[8];
            o.p[6] = ~(st.a[7] ^ m[7]) & (st.a[7] ^ sum[7]);
         end
         default: ;
      endcase
      return o;
   endfunction

   logic        fin;
   logic [2:0]  fin_cyc;
   logic        taken;
   logic        is_st_zp;
   logic [7:0]  store_val;
   logic [15:0] next_pc;
   logic [15:0] tgt;
   logic [15:0] eff;
   logic [15:0] base;
   logic [15:0] ret_pc;
   logic [7:0]  rmw;

   always_comb begin
      nxt       = cur;
      res       = '0;
      fin       = 1'b0;
      fin_cyc   = 3'd0;
      taken     = 1'b0;
      tgt       = 16'h0;
      eff       = 16'h0;
      base      = 16'h0;
      rmw       = 8'h0;
      next_pc   = cur.pc + 16'd1;
      ret_pc    = cur.pc;
      is_st_zp  = (cur.op == cpu6502_pkg::OP_STA_ZP) || (cur.op == cpu6502_pkg::OP_STX_ZP) ||
                  (cur.op == cpu6502_pkg::OP_STY_ZP);
      if ((cur.op == cpu6502_pkg::OP_STX_ZP) || (cur.op == cpu6502_pkg::OP_STX_ABS))
         store_val = cur.x;
      else if (cur.op == cpu6502_pkg::OP_STY_ZP)
         store_val = cur.y;
      else
         store_val = cur.a;

      if (command == cpu6502_pkg::CMD_START) begin
         nxt.pc    = cfg.start_address;
         nxt.sp    = cfg.stack_start;
         nxt.p     = cfg.status_start;
         nxt.a     = 8'h00;
         nxt.x     = 8'h00;
         nxt.y     = 8'h00;
         nxt.halt  = 1'b0;
         nxt.oa    = 16'h0;
         nxt.latch = 8'h00;
         nxt.step  = cpu6502_pkg::STEP_FETCH;
         res.bus_address = cfg.start_address;
      end else if (cur.step == cpu6502_pkg::STEP_IDLE) begin
         res.bus_address = cur.pc;
      end else if (cur.step == cpu6502_pkg::STEP_FETCH) begin
         nxt.op = read_data;
         nxt.pc = next_pc;
         unique case (read_data)
            cpu6502_pkg::OP_CLC: begin nxt.p[0] = 1'b0; fin = 1'b1; fin_cyc = 3'd2; end
            cpu6502_pkg::OP_SEC: begin nxt.p[0] = 1'b1; fin = 1'b1; fin_cyc = 3'd2; end
            cpu6502_pkg::OP_SEI: begin nxt.p[2] = 1'b1; fin = 1'b1; fin_cyc = 3'd2; end
            cpu6502_pkg::OP_DEY: begin
               nxt.y = cur.y - 8'd1; nxt.p = set_nz(cur.p, cur.y - 8'd1);
               fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_DEX: begin
               nxt.x = cur.x - 8'd1; nxt.p = set_nz(cur.p, cur.x - 8'd1);
               fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_INY: begin
               nxt.y = cur.y + 8'd1; nxt.p = set_nz(cur.p, cur.y + 8'd1);
               fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_INX: begin
               nxt.x = cur.x + 8'd1; nxt.p = set_nz(cur.p, cur.x + 8'd1);
               fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_TAX: begin
               nxt.x = cur.a; nxt.p = set_nz(cur.p, cur.a); fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_TAY: begin
               nxt.y = cur.a; nxt.p = set_nz(cur.p, cur.a); fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_TXA: begin
               nxt.a = cur.x; nxt.p = set_nz(cur.p, cur.x); fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_TYA: begin
               nxt.a = cur.y; nxt.p = set_nz(cur.p, cur.y); fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_NOP: begin fin = 1'b1; fin_cyc = 3'd2; end
            cpu6502_pkg::OP_PHA: begin
               res.bus_address = {cpu6502_pkg::STACK_PAGE, cur.sp};
               res.bus_write   = 1'b1;
               res.write_data  = cur.a;
               nxt.sp          = cur.sp - 8'd1;
               nxt.step        = cpu6502_pkg::STEP_OPER;
            end
            cpu6502_pkg::OP_PLA, cpu6502_pkg::OP_RTS, cpu6502_pkg::OP_RTI: begin
               nxt.sp          = cur.sp + 8'd1;
               res.bus_address = {cpu6502_pkg::STACK_PAGE, cur.sp + 8'd1};
               nxt.step        = cpu6502_pkg::STEP_OPER;
            end
            cpu6502_pkg::OP_ADC_IMM, cpu6502_pkg::OP_AND_IMM, cpu6502_pkg::OP_EOR_IMM,
            cpu6502_pkg::OP_LDA_IMM, cpu6502_pkg::OP_LDX_IMM, cpu6502_pkg::OP_LDY_IMM,
            cpu6502_pkg::OP_CMP_IMM, cpu6502_pkg::OP_BPL, cpu6502_pkg::OP_BCC,
            cpu6502_pkg::OP_BCS, cpu6502_pkg::OP_BNE, cpu6502_pkg::OP_BEQ,
            cpu6502_pkg::OP_LDA_ZP, cpu6502_pkg::OP_CMP_ZP, cpu6502_pkg::OP_STA_ZP,
            cpu6502_pkg::OP_STX_ZP, cpu6502_pkg::OP_STY_ZP, cpu6502_pkg::OP_DEC_ZP,
            cpu6502_pkg::OP_INC_ZP, cpu6502_pkg::OP_BIT_ABS, cpu6502_pkg::OP_CMP_ABS,
            cpu6502_pkg::OP_LDA_ABS, cpu6502_pkg::OP_LDA_ABSX, cpu6502_pkg::OP_STA_ABS,
            cpu6502_pkg::OP_STX_ABS, cpu6502_pkg::OP_INC_ABS, cpu6502_pkg::OP_JMP_ABS,
            cpu6502_pkg::OP_JSR, cpu6502_pkg::OP_LDA_INDY: begin
               res.bus_address = next_pc;
               nxt.step        = cpu6502_pkg::STEP_OPER;
            end
            default: begin
               // unknown opcode: halt until the next start
               nxt.halt        = 1'b1;
               nxt.step        = cpu6502_pkg::STEP_IDLE;
               res.bus_address = next_pc;
            end
         endcase
      end else begin
         unique case (cur.op)
            cpu6502_pkg::OP_ADC_IMM, cpu6502_pkg::OP_AND_IMM, cpu6502_pkg::OP_EOR_IMM,
            cpu6502_pkg::OP_LDA_IMM, cpu6502_pkg::OP_LDX_IMM, cpu6502_pkg::OP_LDY_IMM,
            cpu6502_pkg::OP_CMP_IMM: begin
               nxt    = apply_rd(cur, read_data);
               nxt.pc = next_pc;
               fin = 1'b1; fin_cyc = 3'd2;
            end
            cpu6502_pkg::OP_BPL, cpu6502_pkg::OP_BCC, cpu6502_pkg::OP_BCS,
            cpu6502_pkg::OP_BNE, cpu6502_pkg::OP_BEQ: begin
               unique case (cur.op)
                  cpu6502_pkg::OP_BPL: taken = ~cur.p[7];
                  cpu6502_pkg::OP_BCC: taken = ~cur.p[0];
                  cpu6502_pkg::OP_BCS: taken = cur.p[0];
                  cpu6502_pkg::OP_BNE: taken = ~cur.p[1];
                  default:             taken = cur.p[1];
               endcase
               tgt     = next_pc + {{8{read_data[7]}}, read_data};
               nxt.pc  = taken ? tgt : next_pc;
               fin     = 1'b1;
               fin_cyc = !taken ? 3'd2 : ((tgt[15:8] != next_pc[15:8]) ? 3'd4 : 3'd3);
            end
            cpu6502_pkg::OP_LDA_ZP, cpu6502_pkg::OP_CMP_ZP, cpu6502_pkg::OP_STA_ZP,
            cpu6502_pkg::OP_STX_ZP, cpu6502_pkg::OP_STY_ZP, cpu6502_pkg::OP_DEC_ZP,
            cpu6502_pkg::OP_INC_ZP: begin
               if (cur.step == cpu6502_pkg::STEP_OPER) begin
                  nxt.oa          = {8'h00, read_data};
                  nxt.pc          = next_pc;
                  res.bus_address = {8'h00, read_data};
                  res.bus_write   = is_st_zp;
                  res.write_data  = is_st_zp ? store_val : 8'h00;
                  nxt.step        = cpu6502_pkg::STEP_3;
               end else if (cur.step == cpu6502_pkg::STEP_3) begin
                  if (is_st_zp) begin
                     fin = 1'b1; fin_cyc = 3'd3;
                  end else if ((cur.op == cpu6502_pkg::OP_DEC_ZP) ||
                               (cur.op == cpu6502_pkg::OP_INC_ZP)) begin
                     rmw = (cur.op == cpu6502_pkg::OP_INC_ZP) ? read_data + 8'd1
                                                             : read_data - 8'd1;
                     nxt.p           = set_nz(cur.p, rmw);
                     nxt.latch       = rmw;
                     res.bus_address = cur.oa;
                     res.bus_write   = 1'b1;
                     res.write_data  = rmw;
                     nxt.step        = cpu6502_pkg::STEP_4;
                  end else begin
                     nxt = apply_rd(cur, read_data);
                     fin = 1'b1; fin_cyc = 3'd3;
                  end
               end else begin
                  fin = 1'b1; fin_cyc = 3'd5;
               end
            end
            cpu6502_pkg::OP_BIT_ABS, cpu6502_pkg::OP_CMP_ABS, cpu6502_pkg::OP_LDA_ABS,
            cpu6502_pkg::OP_LDA_ABSX, cpu6502_pkg::OP_STA_ABS, cpu6502_pkg::OP_STX_ABS,
            cpu6502_pkg::OP_INC_ABS, cpu6502_pkg::OP_JMP_ABS, cpu6502_pkg::OP_JSR: begin
               if (cur.step == cpu6502_pkg::STEP_OPER) begin
                  nxt.oa          = {8'h00, read_data};
                  nxt.pc          = next_pc;
                  res.bus_address = next_pc;
                  nxt.step        = cpu6502_pkg::STEP_3;
               end else if (cur.step == cpu6502_pkg::STEP_3) begin
                  nxt.oa   = {read_data, cur.oa[7:0]};
                  nxt.pc   = next_pc;
                  nxt.step = cpu6502_pkg::STEP_4;
                  ret_pc   = cur.pc;
                  if (cur.op == cpu6502_pkg::OP_JMP_ABS) begin
                     nxt.pc = {read_data, cur.oa[7:0]};
                     fin = 1'b1; fin_cyc = 3'd3;
                  end else if (cur.op == cpu6502_pkg::OP_JSR) begin
                     // return address minus one, high byte first
                     res.bus_address = {cpu6502_pkg::STACK_PAGE, cur.sp};
                     res.bus_write   = 1'b1;
                     res.write_data  = ret_pc[15:8];
                     nxt.sp          = cur.sp - 8'd1;
                  end else if ((cur.op == cpu6502_pkg::OP_STA_ABS) ||
                               (cur.op == cpu6502_pkg::OP_STX_ABS)) begin
                     res.bus_address = {read_data, cur.oa[7:0]};
                     res.bus_write   = 1'b1;
                     res.write_data  = store_val;
                  end else if (cur.op == cpu6502_pkg::OP_LDA_ABSX) begin
                     eff             = {read_data, cur.oa[7:0]} + {8'h00, cur.x};
                     nxt.latch       = {7'h00, (eff[15:8] != read_data)};
                     nxt.oa          = eff;
                     res.bus_address = eff;
                  end else begin
                     res.bus_address = {read_data, cur.oa[7:0]};
                  end
               end else if (cur.step == cpu6502_pkg::STEP_4) begin
                  ret_pc = cur.pc - 16'd1;
                  if (cur.op == cpu6502_pkg::OP_JSR) begin
                     res.bus_address = {cpu6502_pkg::STACK_PAGE, cur.sp};
                     res.bus_write   = 1'b1;
                     res.write_data  = ret_pc[7:0];
                     nxt.sp          = cur.sp - 8'd1;
                     nxt.step        = cpu6502_pkg::STEP_5;
                  end else if ((cur.op == cpu6502_pkg::OP_STA_ABS) ||
                               (cur.op == cpu6502_pkg::OP_STX_ABS)) begin
                     fin = 1'b1; fin_cyc = 3'd4;
                  end else if (cur.op == cpu6502_pkg::OP_INC_ABS) begin
                     rmw             = read_data + 8'd1;
                     nxt.p           = set_nz(cur.p, rmw);
                     res.bus_address = cur.oa;
                     res.bus_write   = 1'b1;
                     res.write_data  = rmw;
                     nxt.step        = cpu6502_pkg::STEP_5;
                  end else begin
                     nxt     = apply_rd(cur, read_data);
                     fin     = 1'b1;
                     fin_cyc = (cur.op == cpu6502_pkg::OP_LDA_ABSX) ?
                               3'd4 + cur.latch[2:0] : 3'd4;
                  end
               end else begin
                  if (cur.op == cpu6502_pkg::OP_JSR) nxt.pc = cur.oa;
                  fin = 1'b1; fin_cyc = 3'd6;
               end
            end
            cpu6502_pkg::OP_LDA_INDY: begin
               if (cur.step == cpu6502_pkg::STEP_OPER) begin
                  nxt.oa          = {8'h00, read_data};
                  nxt.pc          = next_pc;
                  res.bus_address = {8'h00, read_data};
                  nxt.step        = cpu6502_pkg::STEP_3;
               end else if (cur.step == cpu6502_pkg::STEP_3) begin
                  // pointer high byte wraps within page zero
                  nxt.latch       = read_data;
                  res.bus_address = {8'h00, cur.oa[7:0] + 8'd1};
                  nxt.step        = cpu6502_pkg::STEP_4;
               end else if (cur.step == cpu6502_pkg::STEP_4) begin
                  base            = {read_data, cur.latch};
                  eff             = base + {8'h00, cur.y};
                  nxt.latch       = {7'h00, (eff[15:8] != read_data)};
                  nxt.oa          = eff;
                  res.bus_address = eff;
                  nxt.step        = cpu6502_pkg::STEP_5;
               end else begin
                  nxt     = apply_rd(cur, read_data);
                  fin     = 1'b1;
                  fin_cyc = 3'd5 + cur.latch[2:0];
               end
            end
            cpu6502_pkg::OP_PHA: begin fin = 1'b1; fin_cyc = 3'd3; end
            cpu6502_pkg::OP_PLA: begin
               nxt.a = read_data;
               nxt.p = set_nz(cur.p, read_data);
               fin = 1'b1; fin_cyc = 3'd4;
            end
            cpu6502_pkg::OP_RTS: begin
               if (cur.step == cpu6502_pkg::STEP_OPER) begin
                  nxt.latch       = read_data;
                  nxt.sp          = cur.sp + 8'd1;
                  res.bus_address = {cpu6502_pkg::STACK_PAGE, cur.sp + 8'd1};
                  nxt.step        = cpu6502_pkg::STEP_3;
               end else begin
                  nxt.pc = {read_data, cur.latch} + 16'd1;
                  fin = 1'b1; fin_cyc = 3'd6;
               end
            end
            cpu6502_pkg::OP_RTI: begin
               if (cur.step == cpu6502_pkg::STEP_OPER) begin
                  nxt.p           = read_data;
                  nxt.sp          = cur.sp + 8'd1;
                  res.bus_address = {cpu6502_pkg::STACK_PAGE, cur.sp + 8'd1};
                  nxt.step        = cpu6502_pkg::STEP_3;
               end else if (cur.step == cpu6502_pkg::STEP_3) begin
                  nxt.latch       = read_data;
                  nxt.sp          = cur.sp + 8'd1;
                  res.bus_address = {cpu6502_pkg::STACK_PAGE, cur.sp + 8'd1};
                  nxt.step        = cpu6502_pkg::STEP_4;
               end else begin
                  nxt.pc = {read_data, cur.latch};
                  fin = 1'b1; fin_cyc = 3'd6;
               end
            end
            default: begin
               nxt.step        = cpu6502_pkg::STEP_FETCH;
               res.bus_address = cur.pc;
            end
         endcase
      end

      // instruction complete: report cost and fetch at the new pc
      if (fin) begin
         res.instruction_done   = 1'b1;
         res.instruction_cycles = fin_cyc;
         res.bus_address        = nxt.pc;
         res.bus_write          = 1'b0;
         res.write_data         = 8'h00;
         nxt.step               = cpu6502_pkg::STEP_FETCH;
      end
      res.halted    = nxt.halt;
      res.flags_out = nxt.p;
   end
endmodule

/* sv/cpu_6502_subset_core.sv */
// Top level of the 6502 subset bus-cycle core.
//
// Requests (req_command, req_read_data) arrive on a valid/ready channel: a
// start command loads PC, SP and P from the configuration registers and
// clears A, X, Y and the halt flag; a completion hands back the byte read by
// the previous bus access. Every request yields exactly one response on the
// rsp_ channel: the next bus access, instruction-done status with its cycle
// cost, the halt flag and the current status register.
// The state update and the response are computed in one pass and registered
// together, so a response appears in the cycle after its request is accepted
// and a request can be taken every cycle while rsp_ready is high.
// The response register decouples the sides: a new request is taken while a
// response is still held, as long as that response leaves in the same cycle.
// When rsp_ready stays low the response holds and req_ready drops.
// Reset sets all but the payload register to power-on values; the core then
// waits for a start command and answers completions with a read at PC.
// Users write csr_ configuration only with no request in flight (unchecked).
`timescale 1ns / 1ps
`include "cpu_6502_subset_core_macros.svh"
module cpu_6502_subset_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [7:0]                           req_read_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [15:0]                          rsp_bus_address,
   output logic                                 rsp_bus_write,
   output logic [7:0]                           rsp_write_data,
   output logic                                 rsp_instruction_done,
   output logic [2:0]                           rsp_instruction_cycles,
   output logic                                 rsp_halted,
   output logic [7:0]                           rsp_flags_out,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cpu6502_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   cpu6502_pkg::cfg_type        cfg;
   cpu6502_pkg::core_state_type state_ff;
   cpu6502_pkg::core_state_type state_in;
   cpu6502_pkg::result_type     rsp_ff;
   cpu6502_pkg::result_type     rsp_in;
   logic                        rsp_valid_ff;
   logic                        accept;

   cpu6502_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cpu6502_step u_step (
      .cur       (state_ff),
      .cfg       (cfg),
      .command   (req_command),
      .read_data (req_read_data),
      .nxt       (state_in),
      .res       (rsp_in)
   );

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '{p: 8'h24, sp: 8'hFD, default: '0};
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload register: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_bus_address        = rsp_ff.bus_address;
   assign rsp_bus_write          = rsp_ff.bus_write;
   assign rsp_write_data         = rsp_ff.write_data;
   assign rsp_instruction_done   = rsp_ff.instruction_done;
   assign rsp_instruction_cycles = rsp_ff.instruction_cycles;
   assign rsp_halted             = rsp_ff.halted;
   assign rsp_flags_out          = rsp_ff.flags_out;

   `CPU_ASSERT_IMPL(a_cycles_only_when_done, clock, reset,
      rsp_valid && !rsp_instruction_done, rsp_instruction_cycles == 3'd0)
   `CPU_ASSERT_IMPL(a_no_data_on_read, clock, reset,
      rsp_valid && !rsp_bus_write, rsp_write_data == 8'h00)
   `CPU_ASSERT_IMPL(a_halt_idles, clock, reset,
      state_ff.halt, state_ff.step == cpu6502_pkg::STEP_IDLE)
   `CPU_ASSERT_NEXT(a_accept_gives_rsp, clock, reset,
      accept, rsp_valid && (rsp_halted == state_ff.halt))
endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the 6502 subset bus-cycle core.
`timescale 1ns / 1ps
module tb_top;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int PHASES = 4;

   localparam logic [7:0] KNOWN_OPS [45] = '{
      cpu6502_pkg::OP_CLC, cpu6502_pkg::OP_SEC, cpu6502_pkg::OP_SEI,
      cpu6502_pkg::OP_DEY, cpu6502_pkg::OP_DEX, cpu6502_pkg::OP_INY,
      cpu6502_pkg::OP_INX, cpu6502_pkg::OP_TAX, cpu6502_pkg::OP_TAY,
      cpu6502_pkg::OP_TXA, cpu6502_pkg::OP_TYA, cpu6502_pkg::OP_NOP,
      cpu6502_pkg::OP_PHA, cpu6502_pkg::OP_PLA, cpu6502_pkg::OP_RTS,
      cpu6502_pkg::OP_RTI, cpu6502_pkg::OP_ADC_IMM, cpu6502_pkg::OP_AND_IMM,
      cpu6502_pkg::OP_EOR_IMM, cpu6502_pkg::OP_LDA_IMM, cpu6502_pkg::OP_LDX_IMM,
      cpu6502_pkg::OP_LDY_IMM, cpu6502_pkg::OP_CMP_IMM, cpu6502_pkg::OP_BPL,
      cpu6502_pkg::OP_BCC, cpu6502_pkg::OP_BCS, cpu6502_pkg::OP_BNE,
      cpu6502_pkg::OP_BEQ, cpu6502_pkg::OP_LDA_ZP, cpu6502_pkg::OP_CMP_ZP,
      cpu6502_pkg::OP_STA_ZP, cpu6502_pkg::OP_STX_ZP, cpu6502_pkg::OP_STY_ZP,
      cpu6502_pkg::OP_DEC_ZP, cpu6502_pkg::OP_INC_ZP, cpu6502_pkg::OP_BIT_ABS,
      cpu6502_pkg::OP_CMP_ABS, cpu6502_pkg::OP_LDA_ABS, cpu6502_pkg::OP_LDA_ABSX,
      cpu6502_pkg::OP_STA_ABS, cpu6502_pkg::OP_STX_ABS, cpu6502_pkg::OP_INC_ABS,
      cpu6502_pkg::OP_JMP_ABS, cpu6502_pkg::OP_JSR, cpu6502_pkg::OP_LDA_INDY};

   // Bus access predictor plus the queue of accesses still owed by the core.
   class bus_access_scoreboard;
      logic [15:0] cfg_pc = 16'h8000;
      logic [7:0]  cfg_sp = 8'hFD;
      logic [7:0]  cfg_p  = 8'h24;
      logic [7:0]  acc, xr, yr, flags, sp, op, hold_byte;
      logic [15:0] pc, ea;
      logic [2:0]  step;
      logic        halt;
      cpu6502_pkg::result_type nxt;
      cpu6502_pkg::result_type expected_access[$];
      int          errors;

      function new();
         acc = 0; xr = 0; yr = 0; flags = 8'h24; sp = 8'hFD; pc = 0; op = 0;
         step = cpu6502_pkg::STEP_IDLE; ea = 0; halt = 0; hold_byte = 0; errors = 0;
      endfunction

      function void rd(logic [15:0] adr);
         nxt.bus_address = adr; nxt.bus_write = 0; nxt.write_data = 0;
      endfunction

      function void wr(logic [15:0] adr, logic [7:0] v);
         nxt.bus_address = adr; nxt.bus_write = 1; nxt.write_data = v;
      endfunction

      function void fin(int c);
         nxt.instruction_done = 1;
         nxt.instruction_cycles = c[2:0];
         step = cpu6502_pkg::STEP_FETCH;
         rd(pc);
      endfunction

      function logic [7:0] nz(logic [7:0] v);
         flags = (flags & 8'h7D) | (v & 8'h80) | ((v == 0) ? 8'h02 : 8'h00);
         return v;
      endfunction

      function void push(logic [7:0] v);
         wr({cpu6502_pkg::STACK_PAGE, sp}, v);
         sp = sp - 8'd1;
      endfunction

      function void pull();
         sp = sp + 8'd1;
         rd({cpu6502_pkg::STACK_PAGE, sp});
      endfunction

      function void compare(logic [7:0] m);
         void'(nz(acc - m));
         flags[0] = (acc >= m);
      endfunction

      function void apply(logic [7:0] code, logic [7:0] m);
         logic [8:0] sum;
         case (code)
            cpu6502_pkg::OP_LDA_IMM, cpu6502_pkg::OP_LDA_ZP, cpu6502_pkg::OP_LDA_ABS,
            cpu6502_pkg::OP_LDA_ABSX, cpu6502_pkg::OP_LDA_INDY: acc = nz(m);
            cpu6502_pkg::OP_LDX_IMM: xr = nz(m);
            cpu6502_pkg::OP_LDY_IMM: yr = nz(m);
            cpu6502_pkg::OP_AND_IMM: acc = nz(acc & m);
            cpu6502_pkg::OP_EOR_IMM: acc = nz(acc ^ m);
            cpu6502_pkg::OP_CMP_IMM, cpu6502_pkg::OP_CMP_ZP,
            cpu6502_pkg::OP_CMP_ABS: compare(m);
            cpu6502_pkg::OP_BIT_ABS: begin
               flags = (flags & 8'h3D) | (m & 8'hC0) | (((acc & m) == 0) ? 8'h02 : 8'h00);
            end
            cpu6502_pkg::OP_ADC_IMM: begin
               sum = {1'b0, acc} + {1'b0, m} + {8'd0, flags[0]};
               flags[0] = sum[8];
               flags[6] = ~(acc[7] ^ m[7]) & (acc[7] ^ sum[7]);
               acc = nz(sum[7:0]);
            end
            default: ;
         endcase
      endfunction

      function logic [7:0] store_byte(logic [7:0] code);
         if (code == cpu6502_pkg::OP_STX_ZP || code == cpu6502_pkg::OP_STX_ABS) return xr;
         if (code == cpu6502_pkg::OP_STY_ZP) return yr;
         return acc;
      endfunction

      function bit taken(logic [7:0] code);
         case (code)
            cpu6502_pkg::OP_BPL: return !flags[7];
            cpu6502_pkg::OP_BCC: return !flags[0];
            cpu6502_pkg::OP_BCS: return flags[0];
            cpu6502_pkg::OP_BNE: return !flags[1];
            default:             return flags[1];
         endcase
      endfunction

      function void decode(logic [7:0] d);
         op = d;
         pc = pc + 16'd1;
         case (d)
            cpu6502_pkg::OP_CLC: begin flags[0] = 0; fin(2); end
            cpu6502_pkg::OP_SEC: begin flags[0] = 1; fin(2); end
            cpu6502_pkg::OP_SEI: begin flags[2] = 1; fin(2); end
            cpu6502_pkg::OP_DEY: begin yr = nz(yr - 8'd1); fin(2); end
            cpu6502_pkg::OP_DEX: begin xr = nz(xr - 8'd1); fin(2); end
            cpu6502_pkg::OP_INY: begin yr = nz(yr + 8'd1); fin(2); end
            cpu6502_pkg::OP_INX: begin xr = nz(xr + 8'd1); fin(2); end
            cpu6502_pkg::OP_TAX: begin xr = nz(acc); fin(2); end
            cpu6502_pkg::OP_TAY: begin yr = nz(acc); fin(2); end
            cpu6502_pkg::OP_TXA: begin acc = nz(xr); fin(2); end
            cpu6502_pkg::OP_TYA: begin acc = nz(yr); fin(2); end
            cpu6502_pkg::OP_NOP: fin(2);
            cpu6502_pkg::OP_PHA: begin push(acc); step = cpu6502_pkg::STEP_OPER; end
            cpu6502_pkg::OP_PLA, cpu6502_pkg::OP_RTS, cpu6502_pkg::OP_RTI: begin
               pull();
               step = cpu6502_pkg::STEP_OPER;
            end
            cpu6502_pkg::OP_ADC_IMM, cpu6502_pkg::OP_AND_IMM, cpu6502_pkg::OP_EOR_IMM,
            cpu6502_pkg::OP_LDA_IMM, cpu6502_pkg::OP_LDX_IMM, cpu6502_pkg::OP_LDY_IMM,
            cpu6502_pkg::OP_CMP_IMM, cpu6502_pkg::OP_BPL, cpu6502_pkg::OP_BCC,
            cpu6502_pkg::OP_BCS, cpu6502_pkg::OP_BNE, cpu6502_pkg::OP_BEQ,
            cpu6502_pkg::OP_LDA_ZP, cpu6502_pkg::OP_CMP_ZP, cpu6502_pkg::OP_STA_ZP,
            cpu6502_pkg::OP_STX_ZP, cpu6502_pkg::OP_STY_ZP, cpu6502_pkg::OP_DEC_ZP,
            cpu6502_pkg::OP_INC_ZP, cpu6502_pkg::OP_BIT_ABS, cpu6502_pkg::OP_CMP_ABS,
            cpu6502_pkg::OP_LDA_ABS, cpu6502_pkg::OP_LDA_ABSX, cpu6502_pkg::OP_STA_ABS,
            cpu6502_pkg::OP_STX_ABS, cpu6502_pkg::OP_INC_ABS, cpu6502_pkg::OP_JMP_ABS,
            cpu6502_pkg::OP_JSR, cpu6502_pkg::OP_LDA_INDY: begin
               rd(pc);
               step = cpu6502_pkg::STEP_OPER;
            end
            default: begin
               halt = 1;
               step = cpu6502_pkg::STEP_IDLE;
               rd(pc);
            end
         endcase
      endfunction

      function void zero_page(logic [7:0] d);
         bit st;
         st = (op == cpu6502_pkg::OP_STA_ZP || op == cpu6502_pkg::OP_STX_ZP ||
               op == cpu6502_pkg::OP_STY_ZP);
         if (step == cpu6502_pkg::STEP_OPER) begin
            ea = {8'h00, d};
            pc = pc + 16'd1;
            if (st) wr(ea, store_byte(op));
            else rd(ea);
            step = cpu6502_pkg::STEP_3;
         end else if (step == cpu6502_pkg::STEP_3) begin
            if (st) fin(3);
            else if (op == cpu6502_pkg::OP_DEC_ZP || op == cpu6502_pkg::OP_INC_ZP) begin
               hold_byte = nz((op == cpu6502_pkg::OP_INC_ZP) ? d + 8'd1 : d - 8'd1);
               wr(ea, hold_byte);
               step = cpu6502_pkg::STEP_4;
            end else begin
               apply(op, d);
               fin(3);
            end
         end else fin(5);
      endfunction

      function void absolute(logic [7:0] d);
         logic [15:0] eff, ret;
         if (step == cpu6502_pkg::STEP_OPER) begin
            ea = {8'h00, d};
            pc = pc + 16'd1;
            rd(pc);
            step = cpu6502_pkg::STEP_3;
         end else if (step == cpu6502_pkg::STEP_3) begin
            ea[15:8] = d;
            pc = pc + 16'd1;
            step = cpu6502_pkg::STEP_4;
            ret = pc - 16'd1;
            if (op == cpu6502_pkg::OP_JMP_ABS) begin pc = ea; fin(3); end
            else if (op == cpu6502_pkg::OP_JSR) push(ret[15:8]);
            else if (op == cpu6502_pkg::OP_STA_ABS || op == cpu6502_pkg::OP_STX_ABS)
               wr(ea, store_byte(op));
            else if (op == cpu6502_pkg::OP_LDA_ABSX) begin
               eff = ea + {8'h00, xr};
               hold_byte = {7'd0, eff[15:8] != ea[15:8]};
               ea = eff;
               rd(eff);
            end else rd(ea);
         end else if (step == cpu6502_pkg::STEP_4) begin
            ret = pc - 16'd1;
            if (op == cpu6502_pkg::OP_JSR) begin
               push(ret[7:0]);
               step = cpu6502_pkg::STEP_5;
            end else if (op == cpu6502_pkg::OP_STA_ABS || op == cpu6502_pkg::OP_STX_ABS)
               fin(4);
            else if (op == cpu6502_pkg::OP_INC_ABS) begin
               wr(ea, nz(d + 8'd1));
               step = cpu6502_pkg::STEP_5;
            end else begin
               apply(op, d);
               fin((op == cpu6502_pkg::OP_LDA_ABSX) ? 4 + hold_byte : 4);
            end
         end else begin
            if (op == cpu6502_pkg::OP_JSR) pc = ea;
            fin(6);
         end
      endfunction

      function void indirect_y(logic [7:0] d);
         logic [15:0] base, eff;
         if (step == cpu6502_pkg::STEP_OPER) begin
            ea = {8'h00, d};
            pc = pc + 16'd1;
            rd(ea);
            step = cpu6502_pkg::STEP_3;
         end else if (step == cpu6502_pkg::STEP_3) begin
            hold_byte = d;
            rd({8'h00, ea[7:0] + 8'd1});
            step = cpu6502_pkg::STEP_4;
         end else if (step == cpu6502_pkg::STEP_4) begin
            base = {d, hold_byte};
            eff = base + {8'h00, yr};
            hold_byte = {7'd0, eff[15:8] != base[15:8]};
            ea = eff;
            rd(eff);
            step = cpu6502_pkg::STEP_5;
         end else begin
            apply(cpu6502_pkg::OP_LDA_INDY, d);
            fin(5 + hold_byte);
         end
      endfunction

      function void advance(logic [7:0] d);
         logic [15:0] nx, tgt;
         int c;
         if (step == cpu6502_pkg::STEP_FETCH) begin
            decode(d);
            return;
         end
         case (op)
            cpu6502_pkg::OP_ADC_IMM, cpu6502_pkg::OP_AND_IMM, cpu6502_pkg::OP_EOR_IMM,
            cpu6502_pkg::OP_LDA_IMM, cpu6502_pkg::OP_LDX_IMM, cpu6502_pkg::OP_LDY_IMM,
            cpu6502_pkg::OP_CMP_IMM: begin
               pc = pc + 16'd1;
               apply(op, d);
               fin(2);
            end
            cpu6502_pkg::OP_BPL, cpu6502_pkg::OP_BCC, cpu6502_pkg::OP_BCS,
            cpu6502_pkg::OP_BNE, cpu6502_pkg::OP_BEQ: begin
               nx = pc + 16'd1;
               c = 2;
               pc = nx;
               if (taken(op)) begin
                  tgt = nx + {{8{d[7]}}, d};
                  c = 3 + ((tgt[15:8] != nx[15:8]) ? 1 : 0);
                  pc = tgt;
               end
               fin(c);
            end
            cpu6502_pkg::OP_LDA_ZP, cpu6502_pkg::OP_CMP_ZP, cpu6502_pkg::OP_STA_ZP,
            cpu6502_pkg::OP_STX_ZP, cpu6502_pkg::OP_STY_ZP, cpu6502_pkg::OP_DEC_ZP,
            cpu6502_pkg::OP_INC_ZP: zero_page(d);
            cpu6502_pkg::OP_BIT_ABS, cpu6502_pkg::OP_CMP_ABS, cpu6502_pkg::OP_LDA_ABS,
            cpu6502_pkg::OP_LDA_ABSX, cpu6502_pkg::OP_STA_ABS, cpu6502_pkg::OP_STX_ABS,
            cpu6502_pkg::OP_INC_ABS, cpu6502_pkg::OP_JMP_ABS,
            cpu6502_pkg::OP_JSR: absolute(d);
            cpu6502_pkg::OP_LDA_INDY: indirect_y(d);
            cpu6502_pkg::OP_PHA: fin(3);
            cpu6502_pkg::OP_PLA: begin acc = nz(d); fin(4); end
            cpu6502_pkg::OP_RTS: begin
               if (step == cpu6502_pkg::STEP_OPER) begin
                  hold_byte = d;
                  pull();
                  step = cpu6502_pkg::STEP_3;
               end else begin
                  pc = {d, hold_byte} + 16'd1;
                  fin(6);
               end
            end
            cpu6502_pkg::OP_RTI: begin
               if (step == cpu6502_pkg::STEP_OPER) begin
                  flags = d;
                  pull();
                  step = cpu6502_pkg::STEP_3;
               end else if (step == cpu6502_pkg::STEP_3) begin
                  hold_byte = d;
                  pull();
                  step = cpu6502_pkg::STEP_4;
               end else begin
                  pc = {d, hold_byte};
                  fin(6);
               end
            end
            default: begin
               step = cpu6502_pkg::STEP_FETCH;
               rd(pc);
            end
         endcase
      endfunction

      function void note(logic cmd, logic [7:0] d);
         nxt = '0;
         if (cmd == cpu6502_pkg::CMD_START) begin
            pc = cfg_pc; sp = cfg_sp; flags = cfg_p;
            acc = 0; xr = 0; yr = 0; halt = 0; ea = 0; hold_byte = 0;
            step = cpu6502_pkg::STEP_FETCH;
            rd(pc);
         end else if (step == cpu6502_pkg::STEP_IDLE) rd(pc);
         else advance(d);
         nxt.halted = halt;
         nxt.flags_out = flags;
         expected_access.push_back(nxt);
      endfunction

      function void check(cpu6502_pkg::result_type got);
         cpu6502_pkg::result_type want;
         if (expected_access.size() == 0) begin
            $display("%0t: unexpected response, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_access.pop_front();
         if (got.bus_address !== want.bus_address) begin
            $display("%0t: bus_address expected %h actual %h", $time,
                     want.bus_address, got.bus_address);
            errors++;
         end
         if (got.bus_write !== want.bus_write) begin
            $display("%0t: bus_write expected %h actual %h", $time,
                     want.bus_write, got.bus_write);
            errors++;
         end
         if (got.write_data !== want.write_data) begin
            $display("%0t: write_data expected %h actual %h", $time,
                     want.write_data, got.write_data);
            errors++;
         end
         if (got.instruction_done !== want.instruction_done) begin
            $display("%0t: instruction_done expected %h actual %h", $time,
                     want.instruction_done, got.instruction_done);
            errors++;
         end
         if (got.instruction_cycles !== want.instruction_cycles) begin
            $display("%0t: instruction_cycles expected %h actual %h", $time,
                     want.instruction_cycles, got.instruction_cycles);
            errors++;
         end
         if (got.halted !== want.halted) begin
            $display("%0t: halted expected %h actual %h", $time, want.halted, got.halted);
            errors++;
         end
         if (got.flags_out !== want.flags_out) begin
            $display("%0t: flags_out expected %h actual %h", $time,
                     want.flags_out, got.flags_out);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_command = 1;
   logic [7:0]  req_read_data = 0;
   logic        rsp_valid;
   logic        rsp_ready = 1;
   logic [15:0] rsp_bus_address;
   logic        rsp_bus_write;
   logic [7:0]  rsp_write_data;
   logic        rsp_instruction_done;
   logic [2:0]  rsp_instruction_cycles;
   logic        rsp_halted;
   logic [7:0]  rsp_flags_out;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [cpu6502_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bus_access_scoreboard sb = new();
   int cycles = 0;
   int rx_hold = 0;
   bit tx_busy = 1;
   bit rx_busy = 1;

   cpu_6502_subset_core i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side: check each accepted response, then draw a stall.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check({rsp_bus_address, rsp_bus_write, rsp_write_data,
                      rsp_instruction_done, rsp_instruction_cycles, rsp_halted,
                      rsp_flags_out});
            rx_hold = rx_busy ? $urandom_range(0, 13) : 0;
            rsp_ready <= (rx_hold == 0);
         end else if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= (rx_hold == 0);
         end
      end
   end

   // Call at a rising edge; returns at the edge where the request is taken.
   task automatic send(logic cmd, logic [7:0] d);
      int gap;
      gap = tx_busy ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_read_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note(cmd, d);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_access.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         cpu6502_pkg::CSR_START_ADDRESS: sb.cfg_pc = v[15:0];
         cpu6502_pkg::CSR_STACK_START:   sb.cfg_sp = v[7:0];
         default:                        sb.cfg_p = v[7:0];
      endcase
   endtask

   // Mostly well-formed programs: known opcodes at fetch, random operands.
   task automatic send_random();
      logic [7:0] d;
      d = $urandom_range(0, 255);
      if (sb.step == cpu6502_pkg::STEP_IDLE) begin
         if ($urandom_range(0, 3) != 0) send(cpu6502_pkg::CMD_START, d);
         else send(1'b1, d);
      end else if ($urandom_range(0, 59) == 0) send(cpu6502_pkg::CMD_START, d);
      else begin
         if (sb.step == cpu6502_pkg::STEP_FETCH && $urandom_range(0, 24) != 0)
            d = KNOWN_OPS[$urandom_range(0, 44)];
         send(1'b1, d);
      end
   endtask

   logic [8:0] directed [22] = '{
      {1'b1, 8'h00}, {cpu6502_pkg::CMD_START, 8'hFF},
      {1'b1, cpu6502_pkg::OP_LDA_IMM}, {1'b1, 8'h80},
      {1'b1, cpu6502_pkg::OP_ADC_IMM}, {1'b1, 8'h80},
      {1'b1, cpu6502_pkg::OP_CMP_IMM}, {1'b1, 8'hFF},
      {1'b1, cpu6502_pkg::OP_BNE}, {1'b1, 8'h80},
      {1'b1, cpu6502_pkg::OP_JSR}, {1'b1, 8'hFF},
      {1'b1, 8'hFF}, {1'b1, 8'h00}, {1'b1, 8'h00}, {1'b1, cpu6502_pkg::OP_RTS},
      {1'b1, 8'h34}, {1'b1, 8'h12}, {1'b1, 8'hFF}, {1'b1, 8'h00},
      {1'b1, 8'h55}, {cpu6502_pkg::CMD_START, 8'h00}};

   initial begin
      logic [31:0] cfg [PHASES][3];
      cfg[0] = '{32'h8000, 32'hFD, 32'h24};
      cfg[1] = '{32'h0000, 32'h00, 32'h00};
      cfg[2] = '{32'hFFFF, 32'hFF, 32'hFF};
      cfg[3] = '{$urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 255)};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[k]) send(directed[k][8], directed[k][7:0]);
      for (int ph = 0; ph < PHASES; ph++) begin
         // hold off until the core has answered everything
         drain();
         csr_write(cpu6502_pkg::CSR_START_ADDRESS, cfg[ph][0]);
         csr_write(cpu6502_pkg::CSR_STACK_START, cfg[ph][1]);
         csr_write(cpu6502_pkg::CSR_STATUS_START, cfg[ph][2]);
         send(cpu6502_pkg::CMD_START, $urandom_range(0, 255));
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (n % 100 == 0) begin
               tx_busy = ($urandom_range(0, 2) != 0);
               rx_busy = ($urandom_range(0, 2) != 0);
            end
            send_random();
         end
      end
      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_access.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
